>>> hdl/swt_pkg.sv
// ----------------------------------------------------------------------------
// swt_pkg
// Shared constants and controller/datapath signal groups for the word
// tokenizer.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam int MAX_WORD_DEFAULT = 32;

  localparam logic       KIND_TEXT  = 1'b0;
  localparam logic       KIND_EOT   = 1'b1;

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_HYPHEN  = 8'h2D;
  localparam logic [7:0] CH_APOS    = 8'h27;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CASE_BIT   = 8'h20;

  // controller to datapath
  typedef struct packed {
    logic take;   // input request accepted this cycle
    logic load;   // start emitting the finished word
    logic rd;     // read the store at the emit index
    logic step;   // advance the emit index
  } swt_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_flush;  // current input ends a word
    logic emit_ok;   // pending word is emittable
    logic idx_last;  // emit index is on the final character
  } swt_sts_t;

endpackage

>>> hdl/swt_ifs.sv
// ----------------------------------------------------------------------------
// swt_ifs
// Valid/ready channels for text input and word output.
// ----------------------------------------------------------------------------
interface swt_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] text_byte;

  modport source (output valid, output kind, output text_byte, input ready);
  modport sink   (input valid, input kind, input text_byte, output ready);
endinterface

interface swt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] word_char;
  logic       word_last;

  modport source (output valid, output word_char, output word_last, input ready);
  modport sink   (input valid, input word_char, input word_last, output ready);
endinterface

>>> hdl/swt_ctrl.sv
// ----------------------------------------------------------------------------
// swt_ctrl
// Handshake controller: accepts bytes, then walks the store of a finished
// word one character at a time.
// ----------------------------------------------------------------------------
module swt_ctrl
  import swt_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  swt_sts_t sts,
  output swt_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_SHOW
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SHOW);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take = 1'b1;
          if (sts.is_flush && sts.emit_ok) begin
            cmd.load   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          if (sts.idx_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step   = 1'b1;
            state_next = S_READ;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/swt_dp.sv
// ----------------------------------------------------------------------------
// swt_dp
// Tokenizer datapath: byte classification, word store and word state,
// emit index and output character register.
// ----------------------------------------------------------------------------
module swt_dp
  import swt_pkg::*;
#(
  parameter int MAX_WORD = MAX_WORD_DEFAULT
)(
  input  logic       clk,
  input  logic       rst,
  input  logic       kind,
  input  logic [7:0] text_byte,
  input  swt_cmd_t   cmd,
  output swt_sts_t   sts,
  output logic [7:0] word_char,
  output logic       word_last
);

  localparam int LW = $clog2(MAX_WORD + 1);
  localparam int AW = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;

  logic [7:0]    mem [MAX_WORD];
  logic [7:0]    rd_data;

  logic [LW-1:0] word_length;
  logic [LW-1:0] last_letter_pos;
  logic          letter_seen;
  logic          digit_seen;
  logic          too_long;

  logic [LW-1:0] emit_cnt;
  logic [LW-1:0] emit_idx;

  logic          is_delim;
  logic          is_digit;
  logic          is_letter;
  logic          is_apos;
  logic          full;
  logic          wr_en;
  logic [7:0]    wr_data;

  always_comb begin
    is_delim  = (kind == KIND_EOT) || (text_byte == CH_SPACE) ||
                (text_byte == CH_NEWLINE) || (text_byte == CH_HYPHEN);
    is_digit  = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
    is_letter = ((text_byte >= CH_UPPER_A) && (text_byte <= CH_UPPER_Z)) ||
                ((text_byte >= CH_LOWER_A) && (text_byte <= CH_LOWER_Z));
    is_apos   = (text_byte == CH_APOS);
    full      = (word_length == LW'(MAX_WORD));
    // apostrophes before the first letter are not stored
    wr_en     = cmd.take && !is_delim && !full &&
                (is_letter || (is_apos && letter_seen));
    wr_data   = is_letter ? (text_byte | CASE_BIT) : CH_APOS;
  end

  assign sts.is_flush = is_delim;
  assign sts.emit_ok  = !digit_seen && !too_long && (last_letter_pos != '0);
  assign sts.idx_last = ((emit_idx + LW'(1)) == emit_cnt);

  assign word_char = rd_data;
  assign word_last = sts.idx_last;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[word_length[AW-1:0]] <= wr_data;
    end
    if (cmd.rd) begin
      rd_data <= mem[emit_idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_length     <= '0;
      last_letter_pos <= '0;
      letter_seen     <= 1'b0;
      digit_seen      <= 1'b0;
      too_long        <= 1'b0;
      emit_cnt        <= '0;
      emit_idx        <= '0;
    end else begin
      if (cmd.take) begin
        if (is_delim) begin
          word_length     <= '0;
          last_letter_pos <= '0;
          letter_seen     <= 1'b0;
          digit_seen      <= 1'b0;
          too_long        <= 1'b0;
        end else if (is_digit) begin
          digit_seen <= 1'b1;
        end else if (is_letter) begin
          if (full) begin
            too_long <= 1'b1;
          end else begin
            word_length     <= word_length + LW'(1);
            last_letter_pos <= word_length + LW'(1);
            letter_seen     <= 1'b1;
          end
        end else if (wr_en) begin
          word_length <= word_length + LW'(1);
        end
      end
      if (cmd.load) begin
        emit_cnt <= last_letter_pos;
        emit_idx <= '0;
      end else if (cmd.step) begin
        emit_idx <= emit_idx + LW'(1);
      end
    end
  end

endmodule

>>> hdl/spellcheck_word_tokenizer_top.sv
// ----------------------------------------------------------------------------
// spellcheck_word_tokenizer_top
// Cuts a text byte stream into cleaned lower-case words, one character per
// output request with a last mark.
// ----------------------------------------------------------------------------
// order: a delimiter or end of text is taken while idle; the first character of
//   its word is read from the store in S_READ and shown in S_SHOW
// throughput: one byte per cycle between words; emitting a word takes a store
//   read state and a show state for each character, and no bytes are taken meanwhile
// reset: synchronous, clears the word state and the controller, store
//   contents are left as they are
module spellcheck_word_tokenizer_top
  import swt_pkg::*;
#(
  parameter int MAX_WORD = MAX_WORD_DEFAULT
)(
  input  logic             clk,
  input  logic             rst,
  swt_in_if.sink           text_in,
  swt_out_if.source        word_out
);

  swt_cmd_t cmd;
  swt_sts_t sts;

  swt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (text_in.valid),
    .in_ready  (text_in.ready),
    .out_valid (word_out.valid),
    .out_ready (word_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  swt_dp #(
    .MAX_WORD (MAX_WORD)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .kind      (text_in.kind),
    .text_byte (text_in.text_byte),
    .cmd       (cmd),
    .sts       (sts),
    .word_char (word_out.word_char),
    .word_last (word_out.word_last)
  );

endmodule
